### rtl/core/cbf_pkg.sv
// cbf_pkg: shared types, constants and helpers of the counting bloom filter engine
// no dependencies

package cbf_pkg;

   // default geometry
   localparam int TABLE_DEPTH_DEF  = 4096;
   localparam int MAX_HASHES_DEF   = 8;
   localparam int COUNTER_BITS_DEF = 16;

   // fixed field widths
   localparam int HASH_W    = 64;
   localparam int HASH_NUM  = 8;
   localparam int HSEL_W    = 3;
   localparam int SIZE_W    = 13;
   localparam int HCNT_W    = 4;
   localparam int MODE_W    = 3;
   localparam int OPND_W    = 17;
   localparam int TALLY_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;
   localparam int DIV_W     = SIZE_W;
   localparam int DSTEP_W   = 6;
   localparam int NCNT_W    = SIZE_W + 1;
   localparam int MBIT_W    = 5;
   localparam int CBW_W     = 7;

   // reset values of the registers
   localparam logic [SIZE_W-1:0] SIZE_RST = 13'd4096;
   localparam logic [HCNT_W-1:0] HCNT_RST = 4'd4;
   localparam logic [MODE_W-1:0] MODE_RST = 3'd1;

   // Q16 one
   localparam logic [OPND_W-1:0] Q16_ONE = 17'h10000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_SIZE  = 2'd0,
      CSR_HASH_COUNT   = 2'd1,
      CSR_COUNTER_MODE = 2'd2
   } csr_idx_type;

   // commands
   typedef enum logic [3:0] {
      CMD_LOOKUP     = 4'd0,
      CMD_COUNT      = 4'd1,
      CMD_ADD        = 4'd2,
      CMD_ADD_ABSENT = 4'd3,
      CMD_REMOVE     = 4'd4,
      CMD_CLR_ABOVE  = 4'd5,
      CMD_CLR_ELEM   = 4'd6,
      CMD_LIN_DECAY  = 4'd7,
      CMD_EXP_DECAY  = 4'd8,
      CMD_NONZERO    = 4'd9,
      CMD_ABOVE      = 4'd10,
      CMD_CLEAR      = 4'd11
   } cmd_type;

   // divider request and response
   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [DIV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] quot;
      logic [DIV_W-1:0]  rem;
   } div_rsp_type;

   // ceiling width of a counter mode, undefined modes act as the widest
   function automatic logic [CBW_W-1:0] mode_bits(input logic [MODE_W-1:0] mode);
      logic [CBW_W-1:0] b;
      case (mode)
         3'd0:    b = 7'd4;
         3'd1:    b = 7'd8;
         3'd2:    b = 7'd16;
         3'd3:    b = 7'd32;
         default: b = 7'd64;
      endcase
      return b;
   endfunction

endpackage

### rtl/core/cbf_ram.sv
// cbf_ram: generic single write port, single read port ram with registered read
// no dependencies

module cbf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cbf_divider.sv
// cbf_divider: restoring divider, one quotient bit per cycle
// depends on cbf_pkg

module cbf_divider
   import cbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [HASH_W-1:0]  quot_ff, quot_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   dvsr_ff, dvsr_in;
   logic [DSTEP_W-1:0] step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;

   // one restoring step: shift in the next dividend bit and try the subtract
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[HASH_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvsr_in = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in  = diff[DIV_W-1:0];
            quot_in = {quot_ff[HASH_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIV_W-1:0];
            quot_in = {quot_ff[HASH_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      step_ff <= step_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

### rtl/core/counting_bloom_filter_engine.sv
// counting_bloom_filter_engine: top level, command sequencer over the counter table
// depends on cbf_pkg, cbf_ram and cbf_divider

// Counting bloom filter over a table of TABLE_DEPTH saturating counters held in
// one ram with a registered read. One command is worked at a time; req_ready is
// low while it runs and a finished result may wait in the output register while
// the next command is taken. Hash positions come from a shared divider that
// yields one quotient bit per cycle; an element command first finds the position
// of each hash, then reads the counters in a probe pass and, where the command
// writes, reads and rewrites them in an update pass. Table walks read and
// evaluate each counter in use (exponential decay adds a multiply and a write
// per nonzero counter), and the above tally ends with a division. Clear all
// zeroes the whole table, and after reset the block zeroes the table before it
// accepts its first beat.

module counting_bloom_filter_engine
   import cbf_pkg::*;
#(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int MAX_HASHES   = MAX_HASHES_DEF,
   parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [3:0]           req_cmd,
   input  logic [HASH_W-1:0]    req_hash_0,
   input  logic [HASH_W-1:0]    req_hash_1,
   input  logic [HASH_W-1:0]    req_hash_2,
   input  logic [HASH_W-1:0]    req_hash_3,
   input  logic [HASH_W-1:0]    req_hash_4,
   input  logic [HASH_W-1:0]    req_hash_5,
   input  logic [HASH_W-1:0]    req_hash_6,
   input  logic [HASH_W-1:0]    req_hash_7,
   input  logic [OPND_W-1:0]    req_operand,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_flag,
   output logic [TALLY_W-1:0]   rsp_tally
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int CB  = COUNTER_BITS;
   localparam int PW  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
   localparam int AW_ = CB + OPND_W;

   typedef enum logic [13:0] {
      ST_INIT = 14'b00000000000001,
      ST_IDLE = 14'b00000000000010,
      ST_HASH = 14'b00000000000100,
      ST_PRD  = 14'b00000000001000,
      ST_PEV  = 14'b00000000010000,
      ST_URD  = 14'b00000000100000,
      ST_UWR  = 14'b00000001000000,
      ST_TRD  = 14'b00000010000000,
      ST_TEV  = 14'b00000100000000,
      ST_TMUL = 14'b00001000000000,
      ST_TWR  = 14'b00010000000000,
      ST_DIVQ = 14'b00100000000000,
      ST_CLR  = 14'b01000000000000,
      ST_FIN  = 14'b10000000000000
   } state_type;

   // configuration registers
   logic [SIZE_W-1:0] size_ff;
   logic [HCNT_W-1:0] hcnt_ff;
   logic [MODE_W-1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RST;
         hcnt_ff <= HCNT_RST;
         mode_ff <= MODE_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FILTER_SIZE:  size_ff <= csr_wdata;
            CSR_HASH_COUNT:   hcnt_ff <= csr_wdata[HCNT_W-1:0];
            CSR_COUNTER_MODE: mode_ff <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective size, hash count and ceiling
   logic [SIZE_W-1:0] eff_size;
   logic [HCNT_W-1:0] eff_k;
   logic [CBW_W-1:0]  cbits;
   logic [CB-1:0]     ceil_val;

   always_comb begin
      if (size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (32'(size_ff) > 32'(TABLE_DEPTH)) begin
         eff_size = SIZE_W'(TABLE_DEPTH);
      end else begin
         eff_size = size_ff;
      end
      if (hcnt_ff == '0) begin
         eff_k = HCNT_W'(1);
      end else if (32'(hcnt_ff) > 32'(MAX_HASHES)) begin
         eff_k = HCNT_W'(MAX_HASHES);
      end else begin
         eff_k = hcnt_ff;
      end
      cbits = mode_bits(mode_ff);
      if (32'(cbits) >= 32'(CB)) begin
         ceil_val = '1;
      end else begin
         ceil_val = {CB{1'b1}} >> (CB - 32'(cbits));
      end
   end

   // sequencer registers
   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [HASH_W-1:0]  hash_ff [HASH_NUM];
   logic [OPND_W-1:0]  opnd_ff, opnd_in;
   logic [AW-1:0]      pos_ff [MAX_HASHES];
   logic [HSEL_W-1:0]  sel_ff, sel_in;
   logic [AW-1:0]      walk_ff, walk_in;
   logic [NCNT_W-1:0]  ncnt_ff, ncnt_in;
   logic               allnz_ff, allnz_in;
   logic               above_ff, above_in;
   logic [CB-1:0]      minv_ff, minv_in;
   logic [CB-1:0]      val_ff, val_in;
   logic [AW_-1:0]     acc_ff, acc_in;
   logic [MBIT_W-1:0]  mbit_ff, mbit_in;
   logic               flag_ff, flag_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               go_ff, go_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_flag_ff, rsp_flag_in;
   logic [TALLY_W-1:0] rsp_tally_ff, rsp_tally_in;
   logic               pos_we;
   logic               req_fire;

   // ram and divider hookup
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [CB-1:0] ram_wdata, ram_rdata;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   cbf_ram #(
      .WIDTH (CB),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cbf_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic [AW-1:0]     cur_pos;
   logic              last_hash;
   logic              last_walk;
   logic              last_clr;
   logic [CB:0]       opnd_cmp;
   logic [CB:0]       val_cmp;
   logic              rd_above;
   logic [CB-1:0]     upd_val;
   logic [CB-1:0]     lin_val;
   logic [CB-1:0]     exp_val;

   assign cur_pos   = pos_ff[sel_ff[PW-1:0]];
   assign last_hash = ({1'b0, sel_ff} == (eff_k - 1'b1));
   assign last_walk = (32'(walk_ff) == (32'(eff_size) - 32'd1));
   assign last_clr  = (32'(walk_ff) == (32'(TABLE_DEPTH) - 32'd1));
   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // compare counter against operand at a common width
   always_comb begin
      if (CB >= OPND_W) begin
         opnd_cmp = (CB+1)'(opnd_ff);
         val_cmp  = {1'b0, ram_rdata};
         rd_above = val_cmp > opnd_cmp;
      end else begin
         opnd_cmp = '0;
         val_cmp  = '0;
         rd_above = OPND_W'(ram_rdata) > opnd_ff;
      end
   end

   // counter update values, every write clipped to the ceiling
   always_comb begin
      case (cmd_ff)
         CMD_ADD, CMD_ADD_ABSENT:
            upd_val = (ram_rdata >= ceil_val) ? ceil_val : ram_rdata + 1'b1;
         CMD_REMOVE: begin
            upd_val = (ram_rdata == '0) ? '0 : ram_rdata - 1'b1;
            upd_val = (upd_val > ceil_val) ? ceil_val : upd_val;
         end
         default:
            upd_val = '0;
      endcase
      if (rd_above) begin
         lin_val = ram_rdata - CB'(opnd_ff);
      end else begin
         lin_val = '0;
      end
      lin_val = (lin_val > ceil_val) ? ceil_val : lin_val;
      exp_val = acc_ff[OPND_W-1 +: CB];
      exp_val = (exp_val > ceil_val) ? ceil_val : exp_val;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      opnd_in      = opnd_ff;
      sel_in       = sel_ff;
      walk_in      = walk_ff;
      ncnt_in      = ncnt_ff;
      allnz_in     = allnz_ff;
      above_in     = above_ff;
      minv_in      = minv_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      mbit_in      = mbit_ff;
      flag_in      = flag_ff;
      tally_in     = tally_ff;
      go_in        = 1'b0;
      pos_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_flag_in  = rsp_flag_ff;
      rsp_tally_in = rsp_tally_ff;
      ram_we       = 1'b0;
      ram_waddr    = walk_ff;
      ram_wdata    = '0;
      ram_raddr    = walk_ff;
      div_req.start    = go_ff;
      div_req.dividend = hash_ff[sel_ff];
      div_req.divisor  = eff_size;

      unique case (state_ff)
         // zero the table, one counter a cycle
         ST_INIT, ST_CLR: begin
            ram_we  = 1'b1;
            walk_in = walk_ff + 1'b1;
            if (last_clr) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_FIN;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               opnd_in  = req_operand;
               sel_in   = '0;
               walk_in  = '0;
               ncnt_in  = '0;
               allnz_in = 1'b1;
               above_in = 1'b0;
               minv_in  = '1;
               flag_in  = 1'b0;
               tally_in = '0;
               case (cmd_type'(req_cmd))
                  CMD_LOOKUP, CMD_COUNT, CMD_ADD, CMD_ADD_ABSENT, CMD_REMOVE,
                  CMD_CLR_ABOVE, CMD_CLR_ELEM: begin
                     go_in    = 1'b1;
                     state_in = ST_HASH;
                  end
                  CMD_LIN_DECAY, CMD_NONZERO, CMD_ABOVE:
                     state_in = ST_TRD;
                  CMD_EXP_DECAY:
                     state_in = (req_operand > Q16_ONE) ? ST_FIN : ST_TRD;
                  CMD_CLEAR:
                     state_in = ST_CLR;
                  default:
                     state_in = ST_FIN;
               endcase
            end
         end

         // position of each hash from the divider remainder
         ST_HASH: begin
            if (div_rsp.done) begin
               pos_we = 1'b1;
               if (last_hash) begin
                  sel_in   = '0;
                  state_in = ST_PRD;
               end else begin
                  sel_in = sel_ff + 1'b1;
                  go_in  = 1'b1;
               end
            end
         end

         // probe pass over the positions
         ST_PRD: begin
            ram_raddr = cur_pos;
            state_in  = ST_PEV;
         end

         ST_PEV: begin
            allnz_in = allnz_ff && (ram_rdata != '0);
            above_in = above_ff || rd_above;
            minv_in  = (ram_rdata < minv_ff) ? ram_rdata : minv_ff;
            if (last_hash) begin
               sel_in   = '0;
               state_in = ST_FIN;
               case (cmd_ff)
                  CMD_LOOKUP:
                     flag_in = allnz_in;
                  CMD_COUNT:
                     tally_in = (32'(minv_in) > 32'(16'hFFFF) && CB > TALLY_W) ?
                                '1 : TALLY_W'(minv_in);
                  CMD_ADD, CMD_CLR_ELEM:
                     state_in = ST_URD;
                  CMD_ADD_ABSENT: begin
                     flag_in = allnz_in;
                     if (!allnz_in) state_in = ST_URD;
                  end
                  CMD_REMOVE:
                     if (allnz_in) state_in = ST_URD;
                  CMD_CLR_ABOVE: begin
                     flag_in = above_in;
                     if (above_in) state_in = ST_URD;
                  end
                  default: ;
               endcase
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_PRD;
            end
         end

         // read-modify-write pass, in order so repeats apply twice
         ST_URD: begin
            ram_raddr = cur_pos;
            state_in  = ST_UWR;
         end

         ST_UWR: begin
            ram_we    = 1'b1;
            ram_waddr = cur_pos;
            ram_wdata = upd_val;
            if (last_hash) begin
               state_in = ST_FIN;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_URD;
            end
         end

         // table walk
         ST_TRD: begin
            state_in = ST_TEV;
         end

         ST_TEV: begin
            state_in = ST_TRD;
            case (cmd_ff)
               CMD_NONZERO:
                  if (ram_rdata != '0) ncnt_in = ncnt_ff + 1'b1;
               CMD_ABOVE:
                  if (rd_above) ncnt_in = ncnt_ff + 1'b1;
               CMD_LIN_DECAY:
                  if (ram_rdata != '0) begin
                     ram_we    = 1'b1;
                     ram_wdata = lin_val;
                  end
               default: begin
                  if (ram_rdata != '0) begin
                     val_in   = ram_rdata;
                     acc_in   = '0;
                     mbit_in  = MBIT_W'(OPND_W - 1);
                     state_in = ST_TMUL;
                  end
               end
            endcase
            if (state_in == ST_TRD) begin
               walk_in = walk_ff + 1'b1;
               if (last_walk) begin
                  if (cmd_ff == CMD_ABOVE) begin
                     go_in    = 1'b1;
                     state_in = ST_DIVQ;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
            end
         end

         // shift-add multiply by the Q16 factor, msb first
         ST_TMUL: begin
            acc_in  = {acc_ff[AW_-2:0], 1'b0} +
                      (opnd_ff[mbit_ff] ? AW_'(val_ff) : '0);
            mbit_in = mbit_ff - 1'b1;
            if (mbit_ff == '0) state_in = ST_TWR;
         end

         ST_TWR: begin
            ram_we    = 1'b1;
            ram_wdata = exp_val;
            walk_in   = walk_ff + 1'b1;
            state_in  = last_walk ? ST_FIN : ST_TRD;
         end

         // above tally divided by the hash count
         ST_DIVQ: begin
            div_req.dividend = HASH_W'(ncnt_ff);
            div_req.divisor  = DIV_W'(eff_k);
            if (div_rsp.done) begin
               tally_in = TALLY_W'(div_rsp.quot);
               state_in = ST_FIN;
            end
         end

         // hand the result to the output register
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = flag_ff;
               rsp_tally_in = (cmd_ff == CMD_NONZERO) ? TALLY_W'(ncnt_ff) : tally_ff;
               walk_in      = '0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         walk_ff      <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      opnd_ff      <= opnd_in;
      sel_ff       <= sel_in;
      ncnt_ff      <= ncnt_in;
      allnz_ff     <= allnz_in;
      above_ff     <= above_in;
      minv_ff      <= minv_in;
      val_ff       <= val_in;
      acc_ff       <= acc_in;
      mbit_ff      <= mbit_in;
      flag_ff      <= flag_in;
      tally_ff     <= tally_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_tally_ff <= rsp_tally_in;
      if (pos_we) begin
         pos_ff[sel_ff[PW-1:0]] <= AW'(div_rsp.rem);
      end
      if (req_fire) begin
         hash_ff[0] <= req_hash_0;
         hash_ff[1] <= req_hash_1;
         hash_ff[2] <= req_hash_2;
         hash_ff[3] <= req_hash_3;
         hash_ff[4] <= req_hash_4;
         hash_ff[5] <= req_hash_5;
         hash_ff[6] <= req_hash_6;
         hash_ff[7] <= req_hash_7;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_flag  = rsp_flag_ff;
   assign rsp_tally = rsp_tally_ff;

endmodule
